FILE: src/plcm_pkg.sv
// ----------------------------------------------------------------------------
// plcm_pkg
// Shared constants, types and controller commands for the colour map.
// ----------------------------------------------------------------------------
package plcm_pkg;

  localparam int PaletteDepth = 16;
  localparam int MaxColours   = 4096;

  localparam int KeyW   = 16;
  localparam int ChanW  = 16;
  localparam int CountW = 13;
  localparam int PcntW  = 5;
  localparam int SlotW  = 4;
  localparam int CslotW = 12;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 2;

  // divider widths: scalar numerator up to 12+17 bits, rounded channel operands up to 34 and 18 bits
  localparam int DivNW = 34;
  localparam int DivDW = 18;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_COLOUR = 2'd1;
  localparam logic [1:0] MODE_INDEX  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_RANGE_MIN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RANGE_MAX = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COL_COUNT = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PAL_COUNT = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic wr_pal;    // write palette entry
    logic div_start; // start divider on prepared operands
    logic sel_div;   // 0 scalar or index division, 1 rounded channel division
    logic scan;      // step the interval search
    logic scan_init;
    logic fetch;     // read interval anchors
    logic prep_ch;   // set up channel division
    logic ch_take;   // store channel result
    logic idx_take;  // store index result
    logic scal_take; // store scalar result
    logic out_load;  // load output register
  } plcm_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic scan_done;
  } plcm_sts_t;

endpackage

FILE: src/piecewise_linear_colour_map.sv
// Sequence from the accepting edge to out_valid: palette write or mode 3 go to
// the output register; index query, a division, then the quotient is taken;
// colour query, a scalar division, a scan of the anchors, anchor fetch, then one
// rounded division a channel.
// Throughput: one word at a time; in_ready returns the cycle after the result
// is taken. Reset (synchronous, active low) clears the sequencer and sets the
// registers to range 0..256, 256 colours, 2 anchors; the palette is not cleared.
// ----------------------------------------------------------------------------
// piecewise_linear_colour_map
// Piecewise-linear colour scale with palette store and scalar quantiser.
// ----------------------------------------------------------------------------
module piecewise_linear_colour_map #(
  parameter int PALETTE_DEPTH = plcm_pkg::PaletteDepth,
  parameter int MAX_COLOURS   = plcm_pkg::MaxColours
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [plcm_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [plcm_pkg::CfgW-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic [plcm_pkg::SlotW-1:0]        in_entry_slot,
  input  logic signed [plcm_pkg::KeyW-1:0]  in_entry_key,
  input  logic [plcm_pkg::ChanW-1:0]        in_entry_red,
  input  logic [plcm_pkg::ChanW-1:0]        in_entry_green,
  input  logic [plcm_pkg::ChanW-1:0]        in_entry_blue,
  input  logic [plcm_pkg::CslotW-1:0]       in_colour_slot,
  input  logic signed [plcm_pkg::KeyW-1:0]  in_sample_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [plcm_pkg::ChanW-1:0]        out_red,
  output logic [plcm_pkg::ChanW-1:0]        out_green,
  output logic [plcm_pkg::ChanW-1:0]        out_blue,
  output logic [plcm_pkg::CslotW-1:0]       out_colour_index,
  output logic                              out_out_of_range
);
  import plcm_pkg::*;

  // configuration registers
  logic signed [KeyW-1:0] range_min_r, range_max_r;
  logic [CountW-1:0]      colour_count_r;
  logic [PcntW-1:0]       palette_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r     <= '0;
      range_max_r     <= KeyW'(256);
      colour_count_r  <= CountW'(256);
      palette_count_r <= PcntW'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_MIN: range_min_r     <= cfg_data;
        REG_RANGE_MAX: range_max_r     <= cfg_data;
        REG_COL_COUNT: colour_count_r  <= cfg_data[CountW-1:0];
        REG_PAL_COUNT: palette_count_r <= cfg_data[PcntW-1:0];
        default: ;
      endcase
    end
  end

  plcm_cmd_t  cmd;
  plcm_sts_t  sts;
  logic [1:0] ch_sel;

  // sequencer: one word in flight, result held until taken
  plcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .ch_sel    (ch_sel)
  );

  plcm_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MAX_COLOURS   (MAX_COLOURS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .ch_sel           (ch_sel),
    .in_mode          (in_mode),
    .in_entry_slot    (in_entry_slot),
    .in_entry_key     (in_entry_key),
    .in_entry_red     (in_entry_red),
    .in_entry_green   (in_entry_green),
    .in_entry_blue    (in_entry_blue),
    .in_colour_slot   (in_colour_slot),
    .in_sample_value  (in_sample_value),
    .range_min        (range_min_r),
    .range_max        (range_max_r),
    .colour_count     (colour_count_r),
    .palette_count    (palette_count_r),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_colour_index (out_colour_index),
    .out_out_of_range (out_out_of_range)
  );

endmodule

FILE: src/plcm_div.sv
// ----------------------------------------------------------------------------
// plcm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plcm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [plcm_pkg::DivNW-1:0]    num,
  input  logic [plcm_pkg::DivDW-1:0]    den,
  output logic                          busy,
  output logic [plcm_pkg::DivNW-1:0]    quot,
  output logic [plcm_pkg::DivDW-1:0]    rem
);
  import plcm_pkg::*;

  localparam int CntW = $clog2(DivNW + 1);

  logic [CntW-1:0]  cnt_r;
  logic [DivNW-1:0] q_r;
  logic [DivDW:0]   rem_r;
  logic [DivDW-1:0] den_r;
  logic [DivDW:0]   trial;

  assign trial = {rem_r[DivDW-1:0], q_r[DivNW-1]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CntW'(DivNW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      if (!trial[DivDW]) begin
        rem_r <= trial;
        q_r   <= {q_r[DivNW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DivDW-1:0], q_r[DivNW-1]};
        q_r   <= {q_r[DivNW-2:0], 1'b0};
      end
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = q_r;
  assign rem  = rem_r[DivDW-1:0];

endmodule

FILE: src/plcm_datapath.sv
// ----------------------------------------------------------------------------
// plcm_datapath
// Palette store, interval search, divider and output register.
// ----------------------------------------------------------------------------
module plcm_datapath #(
  parameter int PALETTE_DEPTH = plcm_pkg::PaletteDepth,
  parameter int MAX_COLOURS   = plcm_pkg::MaxColours
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  plcm_pkg::plcm_cmd_t               cmd,
  output plcm_pkg::plcm_sts_t               sts,
  input  logic [1:0]                        ch_sel,
  input  logic [1:0]                        in_mode,
  input  logic [plcm_pkg::SlotW-1:0]        in_entry_slot,
  input  logic signed [plcm_pkg::KeyW-1:0]  in_entry_key,
  input  logic [plcm_pkg::ChanW-1:0]        in_entry_red,
  input  logic [plcm_pkg::ChanW-1:0]        in_entry_green,
  input  logic [plcm_pkg::ChanW-1:0]        in_entry_blue,
  input  logic [plcm_pkg::CslotW-1:0]       in_colour_slot,
  input  logic signed [plcm_pkg::KeyW-1:0]  in_sample_value,
  input  logic signed [plcm_pkg::KeyW-1:0]  range_min,
  input  logic signed [plcm_pkg::KeyW-1:0]  range_max,
  input  logic [plcm_pkg::CountW-1:0]       colour_count,
  input  logic [plcm_pkg::PcntW-1:0]        palette_count,
  output logic [plcm_pkg::ChanW-1:0]        out_red,
  output logic [plcm_pkg::ChanW-1:0]        out_green,
  output logic [plcm_pkg::ChanW-1:0]        out_blue,
  output logic [plcm_pkg::CslotW-1:0]       out_colour_index,
  output logic                              out_out_of_range
);
  import plcm_pkg::*;

  localparam int AddrW = $clog2(PALETTE_DEPTH);
  localparam int EntW  = KeyW + 3 * ChanW;

  logic [EntW-1:0] pal_mem [PALETTE_DEPTH];
  logic [EntW-1:0] rd_data_r;

  logic [1:0]               mode_r;
  logic [SlotW-1:0]         slot_r;
  logic [EntW-1:0]          entry_r;
  logic [CslotW-1:0]        cslot_r;
  logic signed [KeyW-1:0]   samp_r;

  // effective configuration
  logic signed [KeyW-1:0] emax;
  logic [KeyW:0]          span;
  logic [CountW-1:0]      ecnt;
  logic [AddrW:0]         epc;

  always_comb begin
    emax = (range_max < range_min) ? range_min : range_max;
    span = (KeyW+1)'(17'(emax) - 17'(range_min));
    if (colour_count == '0) ecnt = CountW'(1);
    else if (32'(colour_count) > MAX_COLOURS) ecnt = CountW'(MAX_COLOURS);
    else ecnt = colour_count;
    if (palette_count < 5'd2) epc = (AddrW+1)'(2);
    else if (32'(palette_count) > PALETTE_DEPTH) epc = (AddrW+1)'(PALETTE_DEPTH);
    else epc = (AddrW+1)'(palette_count);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      slot_r  <= in_entry_slot;
      entry_r <= {in_entry_key, in_entry_red, in_entry_green, in_entry_blue};
      cslot_r <= in_colour_slot;
      samp_r  <= in_sample_value;
    end
  end

  // scan pointer and lower anchor
  logic [AddrW:0]         scan_r;
  logic [AddrW-1:0]       lo_r;
  logic signed [KeyW-1:0] s_r;
  logic                   fetch_hi_r;

  logic [AddrW-1:0] rd_addr;
  always_comb begin
    if (cmd.fetch) rd_addr = fetch_hi_r ? lo_r + 1'b1 : lo_r;
    else           rd_addr = scan_r[AddrW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pal && 32'(slot_r) < PALETTE_DEPTH)
      pal_mem[AddrW'(slot_r)] <= entry_r;
    rd_data_r <= pal_mem[rd_addr];
  end

  // scan: read entry scan_r, compare in the cycle after
  logic             cmp_v_r;
  logic [AddrW-1:0] cmp_k_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
      scan_r  <= '0;
    end else if (cmd.scan_init) begin
      scan_r  <= '0;
      cmp_v_r <= 1'b0;
    end else if (cmd.scan) begin
      cmp_v_r <= (scan_r + 1'b1 < epc);
      cmp_k_r <= scan_r[AddrW-1:0];
      if (scan_r + 1'b1 < epc) scan_r <= scan_r + 1'b1;
    end else begin
      cmp_v_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.scan_init) lo_r <= '0;
    else if (cmp_v_r && $signed(rd_data_r[EntW-1 -: KeyW]) <= s_r) lo_r <= cmp_k_r;
  end
  assign sts.scan_done = !cmd.scan || (scan_r + 1'b1 >= epc);

  // fetch lower then upper anchor
  logic [EntW-1:0] a_r, b_r;
  logic [1:0]      fph_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fph_r <= '0;
      fetch_hi_r <= 1'b0;
    end else if (cmd.fetch) begin
      fetch_hi_r <= 1'b1;
      fph_r <= fph_r + 1'b1;
    end else begin
      fetch_hi_r <= 1'b0;
      fph_r <= '0;
    end
  end
  always_ff @(posedge clk) begin
    if (fph_r == 2'd1) a_r <= rd_data_r;
    if (fph_r == 2'd2) b_r <= rd_data_r;
  end

  // divider operands
  logic              d_start;
  logic [DivNW-1:0]  d_num;
  logic [DivDW-1:0]  d_den;
  logic              d_busy;
  logic [DivNW-1:0]  d_quot;
  logic [DivDW-1:0]  d_rem;

  logic [DivNW-1:0]  pnum_r;
  logic [DivDW-1:0]  pden_r;
  logic              neg_r;
  logic              zden_r;

  logic [CslotW-1:0] ci;
  logic [CslotW-1:0] cm1;
  always_comb begin
    cm1 = CslotW'(ecnt - 1'b1);
    ci  = (cslot_r > cm1) ? cm1 : cslot_r;
  end

  // channel setup: (chi-clo)*(s-klo), den khi-klo
  logic signed [ChanW+1:0]  dch;
  logic signed [KeyW+1:0]   dks;
  logic signed [KeyW+1:0]   dkk;
  logic [ChanW-1:0]         clo;
  logic signed [ChanW+KeyW+3:0] prod;
  always_comb begin
    case (ch_sel)
      2'd0: begin
        clo = a_r[3*ChanW-1 -: ChanW];
        dch = (ChanW+2)'(b_r[3*ChanW-1 -: ChanW]) - (ChanW+2)'(clo);
      end
      2'd1: begin
        clo = a_r[2*ChanW-1 -: ChanW];
        dch = (ChanW+2)'(b_r[2*ChanW-1 -: ChanW]) - (ChanW+2)'(clo);
      end
      default: begin
        clo = a_r[ChanW-1:0];
        dch = (ChanW+2)'(b_r[ChanW-1:0]) - (ChanW+2)'(clo);
      end
    endcase
    dks = (KeyW+2)'(s_r) - (KeyW+2)'($signed(a_r[EntW-1 -: KeyW]));
    dkk = (KeyW+2)'($signed(b_r[EntW-1 -: KeyW])) -
          (KeyW+2)'($signed(a_r[EntW-1 -: KeyW]));
  end

  logic signed [ChanW+KeyW+3:0] prod_r;
  logic [ChanW-1:0]             clo_r;
  always_ff @(posedge clk) begin
    prod_r <= (ChanW+KeyW+4)'(dch) * (ChanW+KeyW+4)'(dks);
    clo_r  <= clo;
  end
  assign prod = prod_r;

  always_ff @(posedge clk) begin
    if (cmd.prep_ch) begin
      neg_r  <= prod[ChanW+KeyW+3] ^ dkk[KeyW+1];
      zden_r <= (dkk == '0);
      pnum_r <= DivNW'(prod[ChanW+KeyW+3] ? -prod : prod);
      pden_r <= DivDW'(dkk[KeyW+1] ? -dkk : dkk);
    end
  end

  always_comb begin
    if (!cmd.sel_div) begin
      if (mode_r == MODE_INDEX) begin
        d_num = DivNW'(cm1) * DivNW'(17'(samp_r) - 17'(range_min));
      end else begin
        d_num = DivNW'(ci) * DivNW'(span);
      end
      d_den = (mode_r == MODE_INDEX) ? DivDW'(span) : DivDW'(cm1);
    end else begin
      // rounded: (2n + d) / (2d)
      d_num = (pnum_r << 1) + DivNW'(pden_r);
      d_den = pden_r << 1;
    end
  end
  assign d_start = cmd.div_start;

  plcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (d_start),
    .num   (d_num),
    .den   (d_den),
    .busy  (d_busy),
    .quot  (d_quot),
    .rem   (d_rem)
  );
  assign sts.div_busy = d_busy;

  // scalar for colour query
  always_ff @(posedge clk) begin
    if (cmd.scal_take) begin
      if (ecnt > CountW'(1)) s_r <= KeyW'(17'(range_min) + 17'(d_quot));
      else                   s_r <= range_min;
    end
  end

  // channel results
  logic signed [DivNW+1:0] chv;
  logic [ChanW-1:0]        chsat;
  always_comb begin
    if (zden_r) chv = (DivNW+2)'(clo_r);
    else if (neg_r) chv = (DivNW+2)'(clo_r) - (DivNW+2)'(d_quot);
    else chv = (DivNW+2)'(clo_r) + (DivNW+2)'(d_quot);
    if (chv < 0) chsat = '0;
    else if (chv > (DivNW+2)'(65535)) chsat = '1;
    else chsat = chv[ChanW-1:0];
  end

  logic [ChanW-1:0] r_r, g_r, bl_r;
  always_ff @(posedge clk) begin
    if (cmd.ch_take) begin
      case (ch_sel)
        2'd0:    r_r  <= chsat;
        2'd1:    g_r  <= chsat;
        default: bl_r <= chsat;
      endcase
    end
  end

  // index result
  logic [CslotW-1:0] idx_r;
  logic              oor_r;
  always_ff @(posedge clk) begin
    if (cmd.idx_take) begin
      oor_r <= (samp_r < range_min) || (samp_r > emax);
      if ((samp_r < range_min) || (samp_r > emax) || span == '0) idx_r <= '0;
      else idx_r <= d_quot[CslotW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red   <= (mode_r == MODE_COLOUR) ? r_r  : '0;
      out_green <= (mode_r == MODE_COLOUR) ? g_r  : '0;
      out_blue  <= (mode_r == MODE_COLOUR) ? bl_r : '0;
      out_colour_index <= (mode_r == MODE_INDEX) ? idx_r : '0;
      out_out_of_range <= (mode_r == MODE_INDEX) ? oor_r : 1'b0;
    end
  end

  logic unused_ok;
  assign unused_ok = ^d_rem;

endmodule

FILE: src/plcm_ctrl.sv
// ----------------------------------------------------------------------------
// plcm_ctrl
// Sequencer for one word: capture, search, divide, present result.
// ----------------------------------------------------------------------------
module plcm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  output logic                out_valid,
  input  logic                out_ready,
  input  plcm_pkg::plcm_sts_t sts,
  output plcm_pkg::plcm_cmd_t cmd,
  output logic [1:0]          ch_sel
);
  import plcm_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SDIV  = 4'd2;
  localparam logic [3:0] S_SWAIT = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_FETCH = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_PREP  = 4'd8;
  localparam logic [3:0] S_CDIV  = 4'd9;
  localparam logic [3:0] S_CWAIT = 4'd10;
  localparam logic [3:0] S_IWAIT = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_WAIT  = 4'd13;

  logic [3:0] st_r, st_nxt;
  logic [1:0] mode_r;
  logic [1:0] ch_r, ch_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready  = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign ch_sel    = ch_r;

  always_comb begin
    st_nxt  = st_r;
    ch_nxt  = ch_r;
    cnt_nxt = cnt_r;
    ov_nxt  = ov_r;
    cmd     = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (mode_r == MODE_WRITE) begin
          cmd.wr_pal = 1'b1;
          st_nxt = S_OUT;
        end else if (mode_r == MODE_COLOUR || mode_r == MODE_INDEX) begin
          st_nxt = S_SDIV;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_SDIV: begin
        cmd.div_start = 1'b1;
        st_nxt = (mode_r == MODE_INDEX) ? S_IWAIT : S_SWAIT;
      end
      S_SWAIT: begin
        if (!sts.div_busy) begin
          cmd.scal_take = 1'b1;
          cmd.scan_init = 1'b1;
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          st_nxt  = S_DRAIN;
          cnt_nxt = 2'd0;
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd1) begin
          st_nxt  = S_FETCH;
          cnt_nxt = 2'd0;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd2) begin
          st_nxt = S_MUL;
          ch_nxt = 2'd0;
        end
      end
      S_MUL: begin
        st_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep_ch = 1'b1;
        st_nxt = S_CDIV;
      end
      S_CDIV: begin
        cmd.sel_div   = 1'b1;
        cmd.div_start = 1'b1;
        st_nxt = S_CWAIT;
      end
      S_CWAIT: begin
        cmd.sel_div = 1'b1;
        if (!sts.div_busy) begin
          cmd.ch_take = 1'b1;
          if (ch_r == 2'd2) begin
            st_nxt = S_OUT;
          end else begin
            ch_nxt = ch_r + 1'b1;
            st_nxt = S_MUL;
          end
        end
      end
      S_IWAIT: begin
        if (!sts.div_busy) begin
          cmd.idx_take = 1'b1;
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_nxt) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ch_r  <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ch_r  <= ch_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mode_r <= in_mode;
  end

endmodule

FILE: src/plcm_checker.sv
// ----------------------------------------------------------------------------
// plcm_checker
// Port-level checks on the colour map handshakes.
// ----------------------------------------------------------------------------
module plcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_red,
  input logic [11:0] out_colour_index,
  input logic        out_out_of_range
);
  // one word at a time: never ready while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  // accepted word yields no result in the very next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // out of range forces index zero
  a_oor_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_colour_index == '0))
    else $error("index set with out of range");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_red)))
    else $error("result dropped under stall");
endmodule

bind piecewise_linear_colour_map plcm_checker u_plcm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_red          (out_red),
  .out_colour_index (out_colour_index),
  .out_out_of_range (out_out_of_range)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the colour map: palette writes, colour and index
// queries under several register settings and handshake stall patterns.
// ----------------------------------------------------------------------------
module tb;
  import plcm_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 250;
  localparam int PHASE_WORDS    = 125;
  localparam int NUM_PHASES     = 8;

  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  slot;
    logic [15:0] key;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [11:0] cslot;
    logic [15:0] sample;
  } map_word_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [11:0] index;
    logic        oor;
  } map_colour_t;

  typedef struct {
    map_word_t   w;
    bit          typed;
    map_colour_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic [SlotW-1:0] in_entry_slot = '0;
  logic signed [KeyW-1:0] in_entry_key = '0;
  logic [ChanW-1:0] in_entry_red = '0, in_entry_green = '0, in_entry_blue = '0;
  logic [CslotW-1:0] in_colour_slot = '0;
  logic signed [KeyW-1:0] in_sample_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ChanW-1:0] out_red, out_green, out_blue;
  logic [CslotW-1:0] out_colour_index;
  logic out_out_of_range;

  piecewise_linear_colour_map uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block: palette, registers and the colours still owed
  int pal_key [16];
  int pal_ch [16][3];
  int rng_min, rng_max, col_count, pal_count;
  map_colour_t pending_colours[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  task automatic report(string what, int want, int got);
    $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  function automatic longint round_div(longint num, longint den);
    longint n, d, q;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (2 * n + d) / (2 * d);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  // work out the colour owed for one accepted word; writes update the shadow
  function automatic map_colour_t predict_colour(map_word_t w);
    map_colour_t c;
    int mx, cnt, pc, lo, s, i;
    longint span, den, d, v;
    c = '{default: '0};
    mx  = rng_max < rng_min ? rng_min : rng_max;
    cnt = col_count == 0 ? 1 : (col_count > 4096 ? 4096 : col_count);
    pc  = pal_count < 2 ? 2 : (pal_count > 16 ? 16 : pal_count);
    span = longint'(mx) - rng_min;
    case (w.mode)
      MODE_WRITE: begin
        pal_key[w.slot] = int'($signed(w.key));
        pal_ch[w.slot][0] = w.red;
        pal_ch[w.slot][1] = w.green;
        pal_ch[w.slot][2] = w.blue;
      end
      MODE_COLOUR: begin
        s = rng_min;
        if (cnt > 1) begin
          i = w.cslot > cnt - 1 ? cnt - 1 : w.cslot;
          s = rng_min + int'((longint'(i) * span) / (cnt - 1));
        end
        lo = 0;
        for (int k = 0; k + 1 < pc; k++) if (pal_key[k] <= s) lo = k;
        den = longint'(pal_key[lo + 1]) - pal_key[lo];
        d = longint'(s) - pal_key[lo];
        for (int ch = 0; ch < 3; ch++) begin
          v = pal_ch[lo][ch];
          if (den != 0) v += round_div(longint'(pal_ch[lo + 1][ch] - pal_ch[lo][ch]) * d, den);
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          if (ch == 0) c.red = v[15:0];
          else if (ch == 1) c.green = v[15:0];
          else c.blue = v[15:0];
        end
      end
      MODE_INDEX: begin
        s = int'($signed(w.sample));
        if (s < rng_min || s > mx) c.oor = 1'b1;
        else if (span != 0) c.index = 12'(((longint'(cnt) - 1) * (s - rng_min)) / span);
      end
      default: ;
    endcase
    return c;
  endfunction

  // hold the word until accepted, then queue what it owes
  task automatic push_word(map_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_mode = w.mode;
    in_entry_slot = w.slot;
    in_entry_key = w.key;
    in_entry_red = w.red;
    in_entry_green = w.green;
    in_entry_blue = w.blue;
    in_colour_slot = w.cslot;
    in_sample_value = w.sample;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_colours.insert(pending_colours.size(), predict_colour(w));
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid = 1'b0;
    while (pending_colours.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_RANGE_MIN: rng_min = int'($signed(data));
      REG_RANGE_MAX: rng_max = int'($signed(data));
      REG_COL_COUNT: col_count = data[12:0];
      default:       pal_count = data[4:0];
    endcase
  endtask

  // random word; writes keep keys in order most of the time
  function automatic map_word_t random_word();
    map_word_t w;
    int pick, lo_k, hi_k, mx, cnt;
    w.mode = 2'($urandom);
    w.slot = 4'($urandom);
    w.key = 16'($urandom);
    w.red = 16'($urandom);
    w.green = 16'($urandom);
    w.blue = 16'($urandom);
    w.cslot = 12'($urandom);
    w.sample = 16'($urandom);
    pick = $urandom_range(99);
    w.mode = pick < 15 ? MODE_WRITE : pick < 55 ? MODE_COLOUR : pick < 95 ? MODE_INDEX
                                                              : MODE_NONE;
    if (w.mode == MODE_WRITE && $urandom_range(3) != 0) begin
      lo_k = w.slot == 0 ? -32768 : pal_key[w.slot - 1];
      hi_k = w.slot == 15 ? 32767 : pal_key[w.slot + 1];
      if (lo_k <= hi_k) w.key = 16'($urandom_range(hi_k - lo_k) + lo_k);
    end
    mx = rng_max < rng_min ? rng_min : rng_max;
    cnt = col_count == 0 ? 1 : (col_count > 4096 ? 4096 : col_count);
    if ($urandom_range(1)) w.cslot = 12'($urandom_range(cnt - 1));
    if ($urandom_range(1)) w.sample = 16'($urandom_range(mx - rng_min) + rng_min);
    return w;
  endfunction

  // receiver stall pattern
  always @(negedge clk) out_ready = ($urandom_range(99) >= recv_stall_pct);

  // compare each returned word with the oldest colour owed
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending_colours.size() == 0) begin
        report("unexpected result word", 0, 1);
      end else begin
        map_colour_t e;
        e = pending_colours.pop_front();
        if (out_red !== e.red) report("red", e.red, out_red);
        if (out_green !== e.green) report("green", e.green, out_green);
        if (out_blue !== e.blue) report("blue", e.blue, out_blue);
        if (out_colour_index !== e.index) report("colour_index", e.index, out_colour_index);
        if (out_out_of_range !== e.oor) report("out_of_range", e.oor, out_out_of_range);
      end
    end
  end

  // watchdog: drop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic table_row_t row(logic [1:0] m, int slot, int key, int r, int g, int b,
                                     int cs, int smp, bit typed, int er, int eg, int eb,
                                     int ei, int eo);
    table_row_t t;
    t.w = '{m, 4'(slot), 16'(key), 16'(r), 16'(g), 16'(b), 12'(cs), 16'(smp)};
    t.typed = typed;
    t.want = '{16'(er), 16'(eg), 16'(eb), 12'(ei), 1'(eo)};
    return t;
  endfunction

  initial begin
    table_row_t rows[$];
    int range_lo[NUM_PHASES] = '{-32768, 0, -512, 100, -32768, 0, 0, 32767};
    int range_hi[NUM_PHASES] = '{32767, 256, 512, -100, -32768, 0, 0, 32767};
    int counts[NUM_PHASES]   = '{4096, 256, 1, 0, 8191, 0, 0, 2};
    int anchors[NUM_PHASES]  = '{16, 2, 5, 0, 31, 0, 0, 1};

    rng_min = 0; rng_max = 256; col_count = 256; pal_count = 2;
    foreach (pal_key[k]) pal_key[k] = 0;
    foreach (pal_ch[k, c]) pal_ch[k][c] = 0;

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: fill every anchor in key order, then probe the corners
    for (int k = 0; k < 16; k++)
      rows.insert(rows.size(), row(MODE_WRITE, k,
                  k == 0 ? -32768 : k == 15 ? 32767 : (k - 1) * 256,
                  k[0] ? 65535 : 0, k * 4369, 65535 - k * 4369, 0, 0,
                  1, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), row(MODE_INDEX, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), row(MODE_INDEX, 0, 0, 0, 0, 0, 0, 256, 1, 0, 0, 0, 255, 0));
    rows.insert(rows.size(), row(MODE_INDEX, 0, 0, 0, 0, 0, 0, -1, 1, 0, 0, 0, 0, 1));
    rows.insert(rows.size(), row(MODE_INDEX, 0, 0, 0, 0, 0, 0, 257, 1, 0, 0, 0, 0, 1));
    rows.insert(rows.size(), row(MODE_NONE, 15, -1, 65535, 65535, 65535, 4095, -1,
                                 1, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), row(MODE_COLOUR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), row(MODE_COLOUR, 0, 0, 0, 0, 0, 255, 0, 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), row(MODE_COLOUR, 0, 0, 0, 0, 0, 4095, 0, 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), row(MODE_WRITE, 1, -32768, 1, 2, 3, 0, 0, 1, 0, 0, 0, 0, 0));
    foreach (rows[n]) begin
      push_word(rows[n].w);
      // replace the predicted colour with the one read off by hand
      if (rows[n].typed) pending_colours[pending_colours.size() - 1] = rows[n].want;
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_and_settle();
      if (ph == 5 || ph == 6) begin
        range_lo[ph] = int'($signed(16'($urandom)));
        range_hi[ph] = range_lo[ph] + $urandom_range(32767 - range_lo[ph]);
        counts[ph] = $urandom_range(1, 4096);
        anchors[ph] = $urandom_range(2, 16);
      end
      write_reg(REG_RANGE_MIN, 16'(range_lo[ph]));
      write_reg(REG_RANGE_MAX, 16'(range_hi[ph]));
      write_reg(REG_COL_COUNT, 16'(counts[ph]));
      write_reg(REG_PAL_COUNT, 16'(anchors[ph]));
      // advance through the four stall patterns
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      repeat (PHASE_WORDS) push_word(random_word());
    end

    drain_and_settle();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
